FILE: rtl/vsd_pkg.sv
// Shared types, kind codes and helper functions for the varint stream decoder.
package vsd_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned KindW  = 2;
    localparam int unsigned ValueW = 64;
    localparam int unsigned ShiftW = 7;
    localparam int unsigned DigitW = 7;

    // Shift position of the last byte allowed for each kind
    localparam logic [ShiftW-1:0] LastShift32 = 7'd28;
    localparam logic [ShiftW-1:0] LastShift16 = 7'd14;
    localparam logic [ShiftW-1:0] LastShift64 = 7'd63;

    typedef enum logic [KindW-1:0] {
        KIND_32 = 2'd0,
        KIND_16 = 2'd1,
        KIND_64 = 2'd2
    } vsd_kind_t;

    // One input byte with its kind selector
    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic [KindW-1:0] kind;
    } vsd_item_t;

    // One decoded result
    typedef struct packed {
        logic [ValueW-1:0] value;
        logic              too_long;
    } vsd_result_t;

    // Decoder state as seen from outside the core
    typedef struct packed {
        logic [ShiftW-1:0] shift;
        logic [KindW-1:0]  kind;
    } vsd_state_t;

    // Last allowed shift; the unused kind code behaves as 64-bit
    function automatic logic [ShiftW-1:0] last_shift(input logic [KindW-1:0] k);
        logic [ShiftW-1:0] r;
        begin
            case (k)
                KIND_32: r = LastShift32;
                KIND_16: r = LastShift16;
                default: r = LastShift64;
            endcase
            return r;
        end
    endfunction

    // Keep only the bits that belong to the kind's width
    function automatic logic [ValueW-1:0] width_mask(input logic [KindW-1:0] k);
        logic [ValueW-1:0] r;
        begin
            case (k)
                KIND_32: r = 64'h0000_0000_FFFF_FFFF;
                KIND_16: r = 64'h0000_0000_0000_FFFF;
                default: r = '1;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: rtl/vsd_in_reg.sv
// Input register stage: captures one byte transfer and holds it until decoded.
module vsd_in_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  vsd_pkg::vsd_item_t  s_item,
    input  logic                advance,
    output logic                item_valid,
    output vsd_pkg::vsd_item_t  item
);
    import vsd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    vsd_item_t item_reg;

    // Take a new byte when empty or when the held byte moves on this cycle
    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/vsd_core.sv
// Decode core: accumulator, shift and kind state with the per-byte shift-or.
module vsd_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  vsd_pkg::vsd_item_t   item,
    input  logic                 advance,
    output logic                 res_valid,
    output vsd_pkg::vsd_result_t result,
    output vsd_pkg::vsd_state_t  state
);
    import vsd_pkg::*;

    logic [ValueW-1:0] acc_reg;
    logic [ValueW-1:0] acc_next;
    logic [ShiftW-1:0] shift_reg;
    logic [ShiftW-1:0] shift_next;
    logic [KindW-1:0]  kind_reg;
    logic [KindW-1:0]  kind_next;

    logic              fire;
    logic              more;
    logic [KindW-1:0]  cur_kind;
    logic [5:0]        sh;
    logic [ValueW-1:0] acc_new;
    logic              at_limit;

    assign fire     = item_valid && advance;
    assign more     = item.data_byte[ByteW-1];
    // Latch the kind on the first byte of a value
    assign cur_kind = (shift_reg == '0) ? item.kind : kind_reg;
    assign sh       = shift_reg[5:0];
    assign acc_new  = acc_reg
                    | ({{(ValueW-DigitW){1'b0}}, item.data_byte[DigitW-1:0]} << sh);
    assign at_limit = ({1'b0, sh} >= last_shift(cur_kind));

    always_comb begin
        acc_next        = acc_reg;
        shift_next      = shift_reg;
        kind_next       = kind_reg;
        res_valid       = 1'b0;
        result.value    = acc_new & width_mask(cur_kind);
        result.too_long = 1'b0;
        if (fire) begin
            if (!more) begin
                // Final byte: emit the value and drop back to idle
                res_valid  = 1'b1;
                acc_next   = '0;
                shift_next = '0;
                kind_next  = '0;
            end else if (at_limit) begin
                // Still continuing on the last allowed byte: report an error
                res_valid       = 1'b1;
                result.value    = '0;
                result.too_long = 1'b1;
                acc_next        = '0;
                shift_next      = '0;
                kind_next       = '0;
            end else begin
                // Continuing byte: advance the shift by one digit
                acc_next   = acc_new;
                shift_next = {1'b0, sh} + ShiftW'(DigitW);
                kind_next  = cur_kind;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            shift_reg <= '0;
            kind_reg  <= '0;
        end else begin
            acc_reg   <= acc_next;
            shift_reg <= shift_next;
            kind_reg  <= kind_next;
        end
    end

    assign state.shift = shift_reg;
    assign state.kind  = kind_reg;

endmodule

FILE: rtl/vsd_out_reg.sv
// Result register stage: holds one decoded result until the receiver takes it.
module vsd_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 res_valid,
    input  vsd_pkg::vsd_result_t result,
    output logic                 advance,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output vsd_pkg::vsd_result_t m_result
);
    import vsd_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    vsd_result_t result_reg;

    // Decode may proceed when the register is empty or being drained
    assign advance = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

endmodule

FILE: rtl/varint_stream_decoder_unit.sv
// Top level of the unsigned LEB128 varint stream decoder.
//
// Input channel (s_): one encoded byte per transfer. s_tdata carries the byte,
// s_tuser the value kind (0 = 32-bit, 1 = 16-bit, 2 or 3 = 64-bit), which is
// sampled only on the first byte of each value.
// Result channel (m_): one transfer per completed value. m_tdata carries the
// decoded bits truncated to the kind's width (16-bit kind as its 16-bit
// two's complement pattern, zero above), m_tuser flags a value that ran past
// 5, 3 or 10 bytes; such a result carries zero data and restarts decoding.
// Continuing bytes produce no result.
// Throughput: one byte per cycle unless the receiver stalls, set by the combinational
// shift-or into the accumulator between the input register and the result register.
// A final byte is held in the input register, decoded by the core and captured in the
// result register, which presents it on m_tvalid; a receiver stall can hold it back.
// Reset clears the decoder to idle and empties both registers.
// When the receiver stalls, the result register holds, the input register
// fills, and s_tready drops until the result is taken.
module varint_stream_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] value
    output logic [0:0]  m_tuser    // [0] too_long
);
    import vsd_pkg::*;

    vsd_item_t   s_item;
    vsd_item_t   item;
    logic        item_valid;
    logic        advance;
    logic        res_valid;
    vsd_result_t result;
    vsd_result_t m_result;
    vsd_state_t  state;

    assign s_item.data_byte = s_tdata;
    assign s_item.kind      = s_tuser;

    vsd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    vsd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .res_valid  (res_valid),
        .result     (result),
        .state      (state)
    );

    vsd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .result    (result),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (m_result)
    );

    assign m_tdata    = m_result.value;
    assign m_tuser[0] = m_result.too_long;

    // An error result never carries data bits
    a_too_long_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("too_long result with nonzero data");

    // Shift never passes the last allowed position of its kind
    a_shift_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state.shift <= LastShift64)
        && !(state.kind == KIND_32 && state.shift > LastShift32)
        && !(state.kind == KIND_16 && state.shift > LastShift16))
        else $error("shift beyond limit for kind");

    // Input side stalls only while a byte is held for decode
    a_stall_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (item_valid && m_tvalid && !m_tready))
        else $error("input stalled without a held byte");

    // A decoded result is presented on the following cycle
    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && advance) |=> m_tvalid)
        else $error("decoded result lost");

endmodule
